>>> sv/arpe_pkg.sv
// Shared types, codes and defaults of the ARP resolution engine.
package arpe_pkg;

  localparam int CACHE_ENTRIES_DEF   = 16;
  localparam int REQUEST_ENTRIES_DEF = 16;
  localparam int QUEUE_ENTRIES_DEF   = 16;
  localparam int CMD_FIFO_DEPTH      = 4;

  localparam logic [1:0] REQ_SEND = 2'd0;
  localparam logic [1:0] REQ_RECV = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  localparam logic [2:0] KIND_IPV4    = 3'd0;
  localparam logic [2:0] KIND_ARP_REQ = 3'd1;
  localparam logic [2:0] KIND_ARP_REP = 3'd2;
  localparam logic [2:0] KIND_DELIVER = 3'd3;
  localparam logic [2:0] KIND_DROP    = 3'd4;

  localparam logic [15:0] ETH_IPV4       = 16'h0800;
  localparam logic [15:0] ETH_ARP        = 16'h0806;
  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
  localparam logic [47:0] MAC_BCAST      = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] REG_OWN_MAC = 2'd0;
  localparam logic [1:0] REG_OWN_IP  = 2'd1;
  localparam logic [1:0] REG_REQ_TO  = 2'd2;
  localparam logic [1:0] REG_TTL     = 2'd3;

  localparam logic [31:0] REQ_TO_RESET = 32'd5000;
  localparam logic [31:0] TTL_RESET    = 32'd30000;

  typedef enum logic [1:0] {
    CMD_SEND,
    CMD_DELIVER,
    CMD_ARP,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] handle;
    logic [31:0] ip;
    logic [47:0] mac;
    logic        reply;
    logic [15:0] elapsed;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [47:0] mac;
    logic [31:0] ip;
    logic [15:0] handle;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLOOK,
    ST_QPUT,
    ST_RSCAN,
    ST_RDEC,
    ST_CSCAN,
    ST_CWRITE,
    ST_FLUSH,
    ST_REPLY,
    ST_CEXP,
    ST_FINISH
  } state_t;

  function automatic logic [31:0] age_of(input logic [31:0] now, input logic [31:0] stamp);
    return now - stamp;
  endfunction

endpackage

>>> sv/arp_resolution_engine_top.sv
// Top level of the ARP resolution engine: configuration registers and block wiring.
// Each table is walked one entry per cycle by the back end while no held result waits
// on a stalled output; the back end takes one command at a time and finishes it
// before it takes the next. A four-entry command queue, a hold register and an
// output register decouple the input and output sides.
// Reset: synchronous rst clears all tables, the queue and time, and sets the registers to their defaults.
module arp_resolution_engine_top #(
  parameter int CACHE_ENTRIES   = arpe_pkg::CACHE_ENTRIES_DEF,
  parameter int REQUEST_ENTRIES = arpe_pkg::REQUEST_ENTRIES_DEF,
  parameter int QUEUE_ENTRIES   = arpe_pkg::QUEUE_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [263:0] s_tdata,  // dgram_handle, next_hop_ip, frame_dst_mac, ethertype,
                                 // payload_ok, arp_opcode, arp_sender_ip,
                                 // arp_sender_mac, arp_target_ip, elapsed_ms
  input  logic [1:0]   s_tuser,  // req_type
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,  // out_mac, out_ip, out_handle
  output logic [2:0]   m_tuser,  // out_kind
  output logic         m_tlast,  // last
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  logic [47:0]    own_mac;
  logic [31:0]    own_ip;
  logic [31:0]    request_timeout_ms;
  logic [31:0]    cache_ttl_ms;
  logic           push, full, pop, valid;
  arpe_pkg::cmd_t push_cmd, head;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac            <= '0;
      own_ip             <= '0;
      request_timeout_ms <= arpe_pkg::REQ_TO_RESET;
      cache_ttl_ms       <= arpe_pkg::TTL_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[4:3])
        arpe_pkg::REG_OWN_MAC: own_mac            <= pwdata[47:0];
        arpe_pkg::REG_OWN_IP:  own_ip             <= pwdata[31:0];
        arpe_pkg::REG_REQ_TO:  request_timeout_ms <= pwdata[31:0];
        arpe_pkg::REG_TTL:     cache_ttl_ms       <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      arpe_pkg::REG_OWN_MAC: prdata = {16'd0, own_mac};
      arpe_pkg::REG_OWN_IP:  prdata = {32'd0, own_ip};
      arpe_pkg::REG_REQ_TO:  prdata = {32'd0, request_timeout_ms};
      arpe_pkg::REG_TTL:     prdata = {32'd0, cache_ttl_ms};
      default:               prdata = '0;
    endcase
  end

  arpe_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .own_mac  (own_mac),
    .own_ip   (own_ip),
    .full     (full),
    .push     (push),
    .cmd      (push_cmd)
  );

  arpe_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .full      (full),
    .pop       (pop),
    .valid     (valid),
    .head      (head)
  );

  arpe_back #(
    .CACHE_ENTRIES   (CACHE_ENTRIES),
    .REQUEST_ENTRIES (REQUEST_ENTRIES),
    .QUEUE_ENTRIES   (QUEUE_ENTRIES)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .cmd_valid          (valid),
    .cmd                (head),
    .cmd_pop            (pop),
    .request_timeout_ms (request_timeout_ms),
    .cache_ttl_ms       (cache_ttl_ms),
    .m_tvalid           (m_tvalid),
    .m_tready           (m_tready),
    .m_tdata            (m_tdata),
    .m_tuser            (m_tuser),
    .m_tlast            (m_tlast)
  );

endmodule

>>> sv/arpe_front.sv
// Front end: accepts input items, filters and classifies them into commands.
module arpe_front (
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [263:0]       s_tdata,  // handle, next_hop_ip, frame_dst_mac, ethertype,
                                       // payload_ok, arp_opcode, arp_sender_ip,
                                       // arp_sender_mac, arp_target_ip, elapsed_ms
  input  logic [1:0]         s_tuser,  // req_type
  input  logic [47:0]        own_mac,
  input  logic [31:0]        own_ip,
  input  logic               full,
  output logic               push,
  output arpe_pkg::cmd_t     cmd
);

  logic [15:0] dgram_handle;
  logic [31:0] next_hop_ip;
  logic [47:0] frame_dst_mac;
  logic [15:0] ethertype;
  logic        payload_ok;
  logic [15:0] arp_opcode;
  logic [31:0] arp_sender_ip;
  logic [47:0] arp_sender_mac;
  logic [31:0] arp_target_ip;
  logic [15:0] elapsed_ms;
  logic        keep;
  logic        for_us;

  assign dgram_handle   = s_tdata[15:0];
  assign next_hop_ip    = s_tdata[47:16];
  assign frame_dst_mac  = s_tdata[95:48];
  assign ethertype      = s_tdata[111:96];
  assign payload_ok     = s_tdata[112];
  assign arp_opcode     = s_tdata[128:113];
  assign arp_sender_ip  = s_tdata[160:129];
  assign arp_sender_mac = s_tdata[208:161];
  assign arp_target_ip  = s_tdata[240:209];
  assign elapsed_ms     = s_tdata[256:241];

  assign for_us = (frame_dst_mac == own_mac) || (frame_dst_mac == arpe_pkg::MAC_BCAST);

  always_comb begin
    keep        = 1'b0;
    cmd.kind    = arpe_pkg::CMD_SEND;
    cmd.handle  = dgram_handle;
    cmd.ip      = next_hop_ip;
    cmd.mac     = arp_sender_mac;
    cmd.reply   = (arp_opcode == arpe_pkg::ARP_OP_REQUEST) && (arp_target_ip == own_ip);
    cmd.elapsed = elapsed_ms;
    case (s_tuser)
      arpe_pkg::REQ_SEND: begin
        keep = 1'b1;
      end
      arpe_pkg::REQ_RECV: begin
        if (for_us && payload_ok && ethertype == arpe_pkg::ETH_IPV4) begin
          keep     = 1'b1;
          cmd.kind = arpe_pkg::CMD_DELIVER;
        end else if (for_us && payload_ok && ethertype == arpe_pkg::ETH_ARP) begin
          keep     = 1'b1;
          cmd.kind = arpe_pkg::CMD_ARP;
          cmd.ip   = arp_sender_ip;
        end
      end
      arpe_pkg::REQ_TICK: begin
        keep     = 1'b1;
        cmd.kind = arpe_pkg::CMD_TICK;
      end
      default: keep = 1'b0;
    endcase
  end

  assign s_tready = !full;
  assign push     = s_tvalid && !full && keep;

endmodule

>>> sv/arpe_fifo.sv
// Short command queue between front end and back end.
module arpe_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  arpe_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output arpe_pkg::cmd_t head
);

  localparam int PW = $clog2(arpe_pkg::CMD_FIFO_DEPTH);

  arpe_pkg::cmd_t mem [arpe_pkg::CMD_FIFO_DEPTH];
  logic [PW-1:0]  wp;
  logic [PW-1:0]  rp;
  logic [PW:0]    cnt;

  assign full  = (cnt == (PW+1)'(arpe_pkg::CMD_FIFO_DEPTH));
  assign valid = (cnt != '0);
  assign head  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      if (push && !pop)      cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

endmodule

>>> sv/arpe_back.sv
// Back end: walks cache, request and queue tables and emits results.
module arpe_back #(
  parameter int CACHE_ENTRIES   = arpe_pkg::CACHE_ENTRIES_DEF,
  parameter int REQUEST_ENTRIES = arpe_pkg::REQUEST_ENTRIES_DEF,
  parameter int QUEUE_ENTRIES   = arpe_pkg::QUEUE_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  arpe_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic [31:0]    request_timeout_ms,
  input  logic [31:0]    cache_ttl_ms,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [95:0]    m_tdata,  // out_mac, out_ip, out_handle
  output logic [2:0]     m_tuser,  // out_kind
  output logic           m_tlast
);

  localparam int CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int RW = (REQUEST_ENTRIES > 1) ? $clog2(REQUEST_ENTRIES) : 1;
  localparam int SW = (CW > RW) ? CW : RW;
  localparam int QI = (QUEUE_ENTRIES > 1) ? $clog2(QUEUE_ENTRIES) : 1;
  localparam int QW = $clog2(QUEUE_ENTRIES + 1);

  arpe_pkg::state_t state, state_next;
  arpe_pkg::cmd_t   cur;
  logic [31:0]      now_ms;
  logic [SW-1:0]    idx;

  logic             cache_v  [CACHE_ENTRIES];
  logic [31:0]      cache_ip [CACHE_ENTRIES];
  logic [47:0]      cache_mac[CACHE_ENTRIES];
  logic [31:0]      cache_st [CACHE_ENTRIES];
  logic             req_v    [REQUEST_ENTRIES];
  logic [31:0]      req_ip   [REQUEST_ENTRIES];
  logic [31:0]      req_st   [REQUEST_ENTRIES];
  logic [31:0]      q_ip     [QUEUE_ENTRIES];
  logic [15:0]      q_h      [QUEUE_ENTRIES];
  logic [31:0]      q_st     [QUEUE_ENTRIES];
  logic [QW-1:0]    qcnt;
  logic [QW-1:0]    rd;
  logic [QW-1:0]    wr;

  logic             fnd, ffree, need;
  logic [SW-1:0]    fidx, freeidx, oidx, slot;
  logic [31:0]      oage;

  arpe_pkg::result_t hold, emit_res;
  logic             hold_v, emit, stall, out_free, push_out;

  logic             c_end, r_end, c_match, q_end, q_hit, q_fresh;
  logic             t_v;
  logic [31:0]      t_ip, t_st, t_age;

  assign c_end   = (idx[CW-1:0] == CW'(CACHE_ENTRIES - 1));
  assign r_end   = (idx[RW-1:0] == RW'(REQUEST_ENTRIES - 1));
  assign c_match = cache_v[idx[CW-1:0]] && (cache_ip[idx[CW-1:0]] == cur.ip);
  assign q_end   = (rd == qcnt);
  assign q_fresh = arpe_pkg::age_of(now_ms, q_st[rd[QI-1:0]]) < request_timeout_ms;
  assign q_hit   = (cur.kind == arpe_pkg::CMD_TICK) ? !q_fresh : (q_ip[rd[QI-1:0]] == cur.ip);
  assign slot    = fnd ? fidx : (ffree ? freeidx : oidx);
  assign out_free = !m_tvalid || m_tready;
  assign cmd_pop  = (state == arpe_pkg::ST_IDLE) && cmd_valid;

  always_comb begin
    if (state == arpe_pkg::ST_RSCAN) begin
      t_v  = req_v[idx[RW-1:0]];
      t_ip = req_ip[idx[RW-1:0]];
      t_st = req_st[idx[RW-1:0]];
    end else begin
      t_v  = cache_v[idx[CW-1:0]];
      t_ip = cache_ip[idx[CW-1:0]];
      t_st = cache_st[idx[CW-1:0]];
    end
    t_age = arpe_pkg::age_of(now_ms, t_st);
  end

  always_comb begin
    emit     = 1'b0;
    emit_res = '0;
    case (state)
      arpe_pkg::ST_IDLE: begin
        if (cmd_valid && cmd.kind == arpe_pkg::CMD_DELIVER) begin
          emit            = 1'b1;
          emit_res.kind   = arpe_pkg::KIND_DELIVER;
          emit_res.handle = cmd.handle;
        end
      end
      arpe_pkg::ST_CLOOK: begin
        if (c_match) begin
          emit            = 1'b1;
          emit_res.kind   = arpe_pkg::KIND_IPV4;
          emit_res.mac    = cache_mac[idx[CW-1:0]];
          emit_res.ip     = cur.ip;
          emit_res.handle = cur.handle;
        end
      end
      arpe_pkg::ST_QPUT: begin
        if (qcnt == QW'(QUEUE_ENTRIES)) begin
          emit            = 1'b1;
          emit_res.kind   = arpe_pkg::KIND_DROP;
          emit_res.ip     = cur.ip;
          emit_res.handle = cur.handle;
        end
      end
      arpe_pkg::ST_RDEC: begin
        if (need) begin
          emit          = 1'b1;
          emit_res.kind = arpe_pkg::KIND_ARP_REQ;
          emit_res.mac  = arpe_pkg::MAC_BCAST;
          emit_res.ip   = cur.ip;
        end
      end
      arpe_pkg::ST_FLUSH: begin
        if (!q_end && q_hit && cur.kind == arpe_pkg::CMD_ARP && q_fresh) begin
          emit            = 1'b1;
          emit_res.kind   = arpe_pkg::KIND_IPV4;
          emit_res.mac    = cur.mac;
          emit_res.ip     = cur.ip;
          emit_res.handle = q_h[rd[QI-1:0]];
        end
      end
      arpe_pkg::ST_REPLY: begin
        if (cur.reply) begin
          emit          = 1'b1;
          emit_res.kind = arpe_pkg::KIND_ARP_REP;
          emit_res.mac  = cur.mac;
          emit_res.ip   = cur.ip;
        end
      end
      default: emit = 1'b0;
    endcase
    stall    = (emit || state == arpe_pkg::ST_FINISH) && hold_v && !out_free;
    push_out = (emit || state == arpe_pkg::ST_FINISH) && hold_v && out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      arpe_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            arpe_pkg::CMD_SEND:    state_next = arpe_pkg::ST_CLOOK;
            arpe_pkg::CMD_DELIVER: state_next = arpe_pkg::ST_FINISH;
            arpe_pkg::CMD_ARP:     state_next = arpe_pkg::ST_CSCAN;
            arpe_pkg::CMD_TICK:    state_next = arpe_pkg::ST_CEXP;
            default:               state_next = arpe_pkg::ST_IDLE;
          endcase
        end
      end
      arpe_pkg::ST_CLOOK: begin
        if (c_match)    state_next = arpe_pkg::ST_FINISH;
        else if (c_end) state_next = arpe_pkg::ST_QPUT;
      end
      arpe_pkg::ST_QPUT:   state_next = arpe_pkg::ST_RSCAN;
      arpe_pkg::ST_RSCAN:  if (r_end) state_next = arpe_pkg::ST_RDEC;
      arpe_pkg::ST_RDEC:   state_next = arpe_pkg::ST_FINISH;
      arpe_pkg::ST_CSCAN:  if (c_end) state_next = arpe_pkg::ST_CWRITE;
      arpe_pkg::ST_CWRITE: state_next = arpe_pkg::ST_FLUSH;
      arpe_pkg::ST_FLUSH: begin
        if (q_end) begin
          state_next = (cur.kind == arpe_pkg::CMD_TICK) ? arpe_pkg::ST_FINISH
                                                        : arpe_pkg::ST_REPLY;
        end
      end
      arpe_pkg::ST_REPLY:  state_next = arpe_pkg::ST_FINISH;
      arpe_pkg::ST_CEXP:   if (c_end) state_next = arpe_pkg::ST_FLUSH;
      arpe_pkg::ST_FINISH: if (!hold_v || out_free) state_next = arpe_pkg::ST_IDLE;
      default:             state_next = arpe_pkg::ST_IDLE;
    endcase
    if (stall) state_next = state;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= arpe_pkg::ST_IDLE;
      now_ms   <= '0;
      qcnt     <= '0;
      hold_v   <= 1'b0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < CACHE_ENTRIES; i++)   cache_v[i] <= 1'b0;
      for (int i = 0; i < REQUEST_ENTRIES; i++) req_v[i]   <= 1'b0;
    end else begin
      state <= state_next;
      if (push_out) begin
        m_tvalid <= 1'b1;
        m_tuser  <= hold.kind;
        m_tdata  <= {hold.handle, hold.ip, hold.mac};
        m_tlast  <= (state == arpe_pkg::ST_FINISH);
        if (state == arpe_pkg::ST_FINISH) hold_v <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (emit && !stall) begin
        hold   <= emit_res;
        hold_v <= 1'b1;
      end
      if (!stall) begin
        case (state)
          arpe_pkg::ST_IDLE: begin
            if (cmd_valid) begin
              cur   <= cmd;
              idx   <= '0;
              fnd   <= 1'b0;
              ffree <= 1'b0;
              need  <= 1'b1;
              rd    <= '0;
              wr    <= '0;
              if (cmd.kind == arpe_pkg::CMD_TICK) now_ms <= now_ms + 32'(cmd.elapsed);
            end
          end
          arpe_pkg::ST_CLOOK: idx <= idx + 1'b1;
          arpe_pkg::ST_QPUT: begin
            idx <= '0;
            if (qcnt != QW'(QUEUE_ENTRIES)) begin
              q_ip[qcnt[QI-1:0]] <= cur.ip;
              q_h[qcnt[QI-1:0]]  <= cur.handle;
              q_st[qcnt[QI-1:0]] <= now_ms;
              qcnt               <= qcnt + 1'b1;
            end
          end
          arpe_pkg::ST_RSCAN, arpe_pkg::ST_CSCAN: begin
            idx <= idx + 1'b1;
            if (t_v && t_ip == cur.ip && !fnd) begin
              fnd  <= 1'b1;
              fidx <= idx;
              if (state == arpe_pkg::ST_RSCAN) need <= (t_age >= request_timeout_ms);
            end
            if (!t_v && !ffree) begin
              ffree   <= 1'b1;
              freeidx <= idx;
            end
            if (idx == '0 || t_age > oage) begin
              oidx <= idx;
              oage <= t_age;
            end
          end
          arpe_pkg::ST_RDEC: begin
            if (need) begin
              req_v[slot[RW-1:0]]  <= 1'b1;
              req_ip[slot[RW-1:0]] <= cur.ip;
              req_st[slot[RW-1:0]] <= now_ms;
            end
          end
          arpe_pkg::ST_CWRITE: begin
            cache_v[slot[CW-1:0]]   <= 1'b1;
            cache_ip[slot[CW-1:0]]  <= cur.ip;
            cache_mac[slot[CW-1:0]] <= cur.mac;
            cache_st[slot[CW-1:0]]  <= now_ms;
          end
          arpe_pkg::ST_FLUSH: begin
            if (q_end) begin
              qcnt <= wr;
            end else begin
              rd <= rd + 1'b1;
              if (!q_hit) begin
                q_ip[wr[QI-1:0]] <= q_ip[rd[QI-1:0]];
                q_h[wr[QI-1:0]]  <= q_h[rd[QI-1:0]];
                q_st[wr[QI-1:0]] <= q_st[rd[QI-1:0]];
                wr               <= wr + 1'b1;
              end
            end
          end
          arpe_pkg::ST_CEXP: begin
            idx <= idx + 1'b1;
            if (t_v && t_age >= cache_ttl_ms) cache_v[idx[CW-1:0]] <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

>>> sv/arpe_checker.sv
// Port-level checker for the ARP resolution engine, bound to the top level.
module arpe_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [95:0]  m_tdata,
  input logic [2:0]   m_tuser,
  input logic         m_tlast
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("result changed while stalled");

  a_req_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == arpe_pkg::KIND_ARP_REQ |->
      m_tdata[47:0] == arpe_pkg::MAC_BCAST && m_tdata[95:80] == 16'd0 && m_tlast)
    else $error("bad ARP request result");

  a_deliver_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == arpe_pkg::KIND_DELIVER |-> m_tlast && m_tdata[79:0] == 80'd0)
    else $error("bad delivery result");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= arpe_pkg::KIND_DROP)
    else $error("unknown result kind");

endmodule

bind arp_resolution_engine_top arpe_checker u_chk (.*);

>>> sim/tb_arp_resolution_engine_top.sv
// Testbench for the ARP resolution engine: directed and random requests checked by a scoreboard.
module tb_arp_resolution_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  REQ_BAD      = 2'd3;
  localparam logic [15:0] ARP_OP_REPLY = 16'd2;

  typedef struct {
    logic [1:0]  req_type;
    logic [15:0] handle;
    logic [31:0] hop_ip;
    logic [47:0] dst_mac;
    logic [15:0] ethertype;
    logic        payload_ok;
    logic [15:0] opcode;
    logic [31:0] snd_ip;
    logic [47:0] snd_mac;
    logic [31:0] tgt_ip;
    logic [15:0] elapsed;
  } arp_item_t;

  typedef struct {
    logic [2:0]  kind;
    logic [47:0] mac;
    logic [31:0] ip;
    logic [15:0] handle;
    logic        last;
  } arp_result_t;

  class arp_scoreboard;
    logic [47:0] own_mac;
    logic [31:0] own_ip, req_to, ttl, now_ms;
    bit          c_v[16];
    logic [31:0] c_ip[16], c_st[16];
    logic [47:0] c_mac[16];
    bit          r_v[16];
    logic [31:0] r_ip[16], r_st[16];
    bit          q_v[16];
    logic [31:0] q_ip[16], q_st[16];
    logic [15:0] q_h[16];
    arp_result_t pending_q[$];
    int errors, results_seen;

    function new();
      own_mac = '0;
      own_ip  = '0;
      req_to  = arpe_pkg::REQ_TO_RESET;
      ttl     = arpe_pkg::TTL_RESET;
      now_ms  = '0;
      foreach (c_v[i]) begin
        c_v[i] = 0;
        r_v[i] = 0;
        q_v[i] = 0;
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [63:0] v);
      case (idx)
        arpe_pkg::REG_OWN_MAC: own_mac = v[47:0];
        arpe_pkg::REG_OWN_IP:  own_ip = v[31:0];
        arpe_pkg::REG_REQ_TO:  req_to = v[31:0];
        default:               ttl = v[31:0];
      endcase
    endfunction

    function int pick_slot(bit v[16], logic [31:0] ips[16], logic [31:0] st[16],
                           logic [31:0] ip);
      int pick;
      logic [31:0] best, a;
      pick = -1;
      best = 0;
      for (int i = 0; i < 16; i++) if (v[i] && ips[i] == ip) return i;
      for (int i = 0; i < 16; i++) if (!v[i]) return i;
      for (int i = 0; i < 16; i++) begin
        a = now_ms - st[i];
        if (pick < 0 || a > best) begin
          pick = i;
          best = a;
        end
      end
      return pick;
    endfunction

    function void drop_queued(int idx);
      for (int i = idx; i < 15; i++) begin
        q_v[i]  = q_v[i+1];
        q_ip[i] = q_ip[i+1];
        q_h[i]  = q_h[i+1];
        q_st[i] = q_st[i+1];
      end
      q_v[15] = 0;
    endfunction

    function void push(logic [2:0] k, logic [47:0] m, logic [31:0] ip, logic [15:0] h);
      arp_result_t r;
      r.kind = k; r.mac = m; r.ip = ip; r.handle = h; r.last = 0;
      pending_q.insert(pending_q.size(), r);
    endfunction

    function void note_request(arp_item_t it);
      int base, q, s, i;
      bit need;
      base = pending_q.size();
      if (it.req_type == arpe_pkg::REQ_SEND) begin
        for (i = 0; i < 16; i++)
          if (c_v[i] && c_ip[i] == it.hop_ip) begin
            push(arpe_pkg::KIND_IPV4, c_mac[i], it.hop_ip, it.handle);
            break;
          end
        if (i == 16) begin
          q = -1;
          for (i = 0; i < 16; i++)
            if (!q_v[i]) begin
              q = i;
              break;
            end
          if (q < 0) push(arpe_pkg::KIND_DROP, '0, it.hop_ip, it.handle);
          else begin
            q_v[q] = 1; q_ip[q] = it.hop_ip; q_h[q] = it.handle; q_st[q] = now_ms;
          end
          need = 1;
          for (i = 0; i < 16; i++)
            if (r_v[i] && r_ip[i] == it.hop_ip) need = (now_ms - r_st[i]) >= req_to;
          if (need) begin
            push(arpe_pkg::KIND_ARP_REQ, arpe_pkg::MAC_BCAST, it.hop_ip, '0);
            s = pick_slot(r_v, r_ip, r_st, it.hop_ip);
            r_v[s] = 1; r_ip[s] = it.hop_ip; r_st[s] = now_ms;
          end
        end
      end else if (it.req_type == arpe_pkg::REQ_RECV) begin
        if ((it.dst_mac == own_mac || it.dst_mac == arpe_pkg::MAC_BCAST) && it.payload_ok) begin
          if (it.ethertype == arpe_pkg::ETH_IPV4) begin
            push(arpe_pkg::KIND_DELIVER, '0, '0, it.handle);
          end else if (it.ethertype == arpe_pkg::ETH_ARP) begin
            s = pick_slot(c_v, c_ip, c_st, it.snd_ip);
            c_v[s] = 1; c_ip[s] = it.snd_ip; c_mac[s] = it.snd_mac; c_st[s] = now_ms;
            i = 0;
            while (i < 16 && q_v[i]) begin
              if (q_ip[i] == it.snd_ip) begin
                if ((now_ms - q_st[i]) < req_to)
                  push(arpe_pkg::KIND_IPV4, it.snd_mac, it.snd_ip, q_h[i]);
                drop_queued(i);
              end else i++;
            end
            if (it.opcode == arpe_pkg::ARP_OP_REQUEST && it.tgt_ip == own_ip)
              push(arpe_pkg::KIND_ARP_REP, it.snd_mac, it.snd_ip, '0);
          end
        end
      end else if (it.req_type == arpe_pkg::REQ_TICK) begin
        now_ms = now_ms + 32'(it.elapsed);
        for (i = 0; i < 16; i++)
          if (c_v[i] && (now_ms - c_st[i]) >= ttl) c_v[i] = 0;
        i = 0;
        while (i < 16 && q_v[i]) begin
          if ((now_ms - q_st[i]) >= req_to) drop_queued(i);
          else i++;
        end
      end
      if (pending_q.size() > base) pending_q[pending_q.size()-1].last = 1;
    endfunction

    function void check_result(arp_result_t got);
      arp_result_t w;
      results_seen++;
      if (pending_q.size() == 0) begin
        $error("unexpected result kind=%0d handle=%h", got.kind, got.handle);
        errors++;
        return;
      end
      w = pending_q.pop_front();
      if (got.kind !== w.kind) begin
        $error("out_kind expected %0d actual %0d", w.kind, got.kind); errors++;
      end
      if (got.mac !== w.mac) begin
        $error("out_mac expected %h actual %h", w.mac, got.mac); errors++;
      end
      if (got.ip !== w.ip) begin
        $error("out_ip expected %h actual %h", w.ip, got.ip); errors++;
      end
      if (got.handle !== w.handle) begin
        $error("out_handle expected %h actual %h", w.handle, got.handle); errors++;
      end
      if (got.last !== w.last) begin
        $error("last expected %0d actual %0d", w.last, got.last); errors++;
      end
    endfunction
  endclass

  logic         clk, rst;
  logic         s_tvalid, s_tready, m_tvalid, m_tready, m_tlast;
  logic [263:0] s_tdata;
  logic [1:0]   s_tuser;
  logic [95:0]  m_tdata;
  logic [2:0]   m_tuser;
  logic         psel, penable, pwrite, pready;
  logic [4:0]   paddr;
  logic [63:0]  pwdata, prdata;

  arp_scoreboard sb;
  bit            calm;
  int            hold_cycles;
  int            stall_left;
  int            items_sent;
  logic [31:0]   ip_pool[24];
  logic [47:0]   mac_pool[24];

  arp_resolution_engine_top u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      m_tready = 1'b0;
      hold_cycles--;
    end else if (stall_left > 0) begin
      m_tready = 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      m_tready = 1'b0;
      stall_left = $urandom_range(0, 5);
    end else m_tready = 1'b1;
  end

  always @(posedge clk) begin
    arp_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.kind = m_tuser; got.mac = m_tdata[47:0]; got.ip = m_tdata[79:48];
      got.handle = m_tdata[95:80]; got.last = m_tlast;
      sb.check_result(got);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] v);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = {idx, 3'b000}; pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic settle();
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (250) @(negedge clk);
  endtask

  task automatic offer(arp_item_t it);
    s_tuser = it.req_type;
    s_tdata = {7'b0, it.elapsed, it.tgt_ip, it.snd_mac, it.snd_ip, it.opcode,
               it.payload_ok, it.ethertype, it.dst_mac, it.hop_ip, it.handle};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_request(it);
    items_sent++;
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  function automatic arp_item_t blank_item(logic [1:0] t);
    arp_item_t it;
    it.req_type = t; it.handle = 16'($urandom); it.hop_ip = $urandom;
    it.dst_mac = 48'({$urandom, $urandom}); it.ethertype = 16'($urandom);
    it.payload_ok = 1'($urandom);
    it.opcode = 16'($urandom); it.snd_ip = $urandom; it.snd_mac = 48'({$urandom, $urandom});
    it.tgt_ip = $urandom; it.elapsed = 16'($urandom);
    return it;
  endfunction

  function automatic arp_item_t arp_msg(int p, logic [15:0] op);
    arp_item_t it;
    it = blank_item(arpe_pkg::REQ_RECV);
    it.dst_mac = $urandom_range(0, 1) ? arpe_pkg::MAC_BCAST : sb.own_mac;
    it.ethertype = arpe_pkg::ETH_ARP; it.payload_ok = 1'b1; it.opcode = op;
    it.snd_ip = ip_pool[p]; it.snd_mac = mac_pool[p];
    if ($urandom_range(0, 2) == 0) it.tgt_ip = sb.own_ip;
    return it;
  endfunction

  function automatic arp_item_t random_item();
    arp_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      it = blank_item(arpe_pkg::REQ_SEND);
      it.hop_ip = ip_pool[$urandom_range(0, 23)];
    end else if (r < 65) begin
      it = arp_msg($urandom_range(0, 23),
                   $urandom_range(0, 3) == 0 ? ARP_OP_REPLY : arpe_pkg::ARP_OP_REQUEST);
    end else if (r < 73) begin
      it = blank_item(arpe_pkg::REQ_RECV);
      it.dst_mac = $urandom_range(0, 1) ? arpe_pkg::MAC_BCAST : sb.own_mac;
      it.ethertype = arpe_pkg::ETH_IPV4; it.payload_ok = 1'b1;
    end else if (r < 88) begin
      it = blank_item(arpe_pkg::REQ_TICK);
      if ($urandom_range(0, 19) != 0) it.elapsed = 16'($urandom_range(0, 40));
    end else if (r < 92) begin
      it = blank_item(REQ_BAD);
    end else begin
      it = blank_item(arpe_pkg::REQ_RECV);
      if ($urandom_range(0, 1)) it.dst_mac = sb.own_mac;
      if ($urandom_range(0, 1))
        it.ethertype = $urandom_range(0, 1) ? arpe_pkg::ETH_ARP : arpe_pkg::ETH_IPV4;
    end
    return it;
  endfunction

  initial begin
    arp_item_t it;
    int phase_items[4];
    logic [31:0] to_set[4], ttl_set[4];
    logic [31:0] lone_ip;
    logic [63:0] mac_val;
    sb = new();
    calm = 0; hold_cycles = 0; stall_left = 0; items_sent = 0;
    rst = 1'b1; s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0; m_tready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    foreach (ip_pool[i]) begin
      ip_pool[i] = $urandom;
      mac_pool[i] = 48'({$urandom, $urandom});
    end
    repeat (8) @(negedge clk);
    rst = 1'b0;
    repeat (2) @(negedge clk);

    // directed: defaults in force until the registers change
    lone_ip = ip_pool[0];
    it = blank_item(arpe_pkg::REQ_RECV); it.dst_mac = '0; it.ethertype = arpe_pkg::ETH_IPV4;
    it.payload_ok = 1'b1; it.handle = 16'hFFFF;
    offer(it);
    s_tvalid = 1'b0;
    settle();
    write_reg(arpe_pkg::REG_OWN_MAC, 64'h0000_FFFF_FFFF_FFFE);
    write_reg(arpe_pkg::REG_OWN_IP, 64'hFFFF_FFFF);
    for (int k = 0; k < 17; k++) begin
      it = blank_item(arpe_pkg::REQ_SEND); it.hop_ip = lone_ip; it.handle = k[15:0];
      offer(it);
    end
    it = arp_msg(0, arpe_pkg::ARP_OP_REQUEST); it.tgt_ip = sb.own_ip; offer(it);
    it = blank_item(arpe_pkg::REQ_SEND); it.hop_ip = lone_ip; it.handle = '0; offer(it);
    it = blank_item(arpe_pkg::REQ_RECV); it.dst_mac = 48'h1; it.ethertype = arpe_pkg::ETH_IPV4;
    it.payload_ok = 1'b1; offer(it);
    it = blank_item(arpe_pkg::REQ_RECV); it.dst_mac = arpe_pkg::MAC_BCAST;
    it.ethertype = arpe_pkg::ETH_ARP; it.payload_ok = 1'b0; offer(it);
    it = blank_item(arpe_pkg::REQ_TICK); it.elapsed = 16'hFFFF; offer(it);
    it = blank_item(REQ_BAD); offer(it);
    it = blank_item(arpe_pkg::REQ_SEND); it.hop_ip = lone_ip; offer(it);
    s_tvalid = 1'b0;
    settle();

    // random phases across timeout and TTL settings
    to_set  = '{32'd60, 32'd1, 32'hFFFF_FFFF, 32'd25};
    ttl_set = '{32'd200, 32'hFFFF_FFFF, 32'd1, 32'd90};
    phase_items = '{150, 100, 100, 120};
    for (int ph = 0; ph < 4; ph++) begin
      mac_val = {16'h0, 48'({$urandom, $urandom})};
      write_reg(arpe_pkg::REG_REQ_TO, {32'h0, to_set[ph]});
      write_reg(arpe_pkg::REG_TTL, {32'h0, ttl_set[ph]});
      write_reg(arpe_pkg::REG_OWN_MAC, ph == 2 ? 64'h0 : mac_val);
      write_reg(arpe_pkg::REG_OWN_IP, ph == 2 ? 64'h0 : {32'h0, ip_pool[ph]});
      for (int k = 0; k < phase_items[ph]; k++) begin
        if (ph == 0 && k == 40) hold_cycles = 400;
        if (ph == 3 && k == 70) calm = 1;
        offer(random_item());
      end
      s_tvalid = 1'b0;
      settle();
    end

    $display("Covered %0d requests and %0d results over four timeout/TTL settings,",
             items_sent, sb.results_seen);
    $display("including queue overflow, queue flush, ARP replies and a long output stall.");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
